[rtl/i2r_pkg.sv]
package i2r_pkg;

    // Field widths fixed by the interface.
    localparam int VALUE_W = 14;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;

    // Default depth of the digit queue between the front and the back.
    localparam int FIFO_DEPTH_DEF = 2;

    // ASCII codes of the numeral letters and of the terminating newline.
    localparam logic [CHAR_W-1:0] CH_I  = 7'h49;
    localparam logic [CHAR_W-1:0] CH_V  = 7'h56;
    localparam logic [CHAR_W-1:0] CH_X  = 7'h58;
    localparam logic [CHAR_W-1:0] CH_L  = 7'h4C;
    localparam logic [CHAR_W-1:0] CH_C  = 7'h43;
    localparam logic [CHAR_W-1:0] CH_D  = 7'h44;
    localparam logic [CHAR_W-1:0] CH_M  = 7'h4D;
    localparam logic [CHAR_W-1:0] CH_NL = 7'd10;

    // Decimal digits of one value, reduced modulo 10000.
    typedef struct packed {
        logic [DIGIT_W-1:0] th;
        logic [DIGIT_W-1:0] hu;
        logic [DIGIT_W-1:0] te;
        logic [DIGIT_W-1:0] on;
    } digits_t;

endpackage

[rtl/i2r_front.sv]
module i2r_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [i2r_pkg::VALUE_W-1:0] value,
    output logic                      q_push,
    input  logic                      q_full,
    output i2r_pkg::digits_t          q_wdata
);
    import i2r_pkg::*;

    // One shift-and-correct step of the binary to BCD conversion per cycle.
    localparam int ITER  = VALUE_W;
    localparam int CNT_W = $clog2(ITER);
    localparam int BCD_W = 4 * DIGIT_W;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t        state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [BCD_W-1:0]    bcd_adj;

    always_comb
    begin
        logic [DIGIT_W-1:0] dig;
        dig = '0;
        for (int i = 0; i < 4; i++)
        begin
            dig = bcd_reg[i*DIGIT_W +: DIGIT_W];
            bcd_adj[i*DIGIT_W +: DIGIT_W] = (dig >= DIGIT_W'(5)) ? dig + DIGIT_W'(3) : dig;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    bin_next   = value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = F_CONV;
                end
            end
            F_CONV:
            begin
                // The carry out of the thousands digit is dropped, which
                // reduces the value modulo 10000.
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ITER - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign full    = (state_reg != F_IDLE);
    assign q_wdata = digits_t'(bcd_reg);

endmodule

[rtl/i2r_fifo.sv]
module i2r_fifo #(
    parameter int DEPTH = i2r_pkg::FIFO_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  i2r_pkg::digits_t wdata,
    input  logic             pop,
    output logic             empty,
    output i2r_pkg::digits_t rdata
);
    import i2r_pkg::*;

    // DEPTH must be at least 2; the module itself does not enforce this.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    digits_t        mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/i2r_back.sv]
module i2r_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  i2r_pkg::digits_t           q_rdata,
    output logic                       q_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic [i2r_pkg::CHAR_W-1:0] character,
    output logic                       last
);
    import i2r_pkg::*;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_TH   = 6'b000010,
        B_HU   = 6'b000100,
        B_TE   = 6'b001000,
        B_ON   = 6'b010000,
        B_NL   = 6'b100000
    } back_state_t;

    typedef enum logic [1:0] {
        SH_ONE  = 2'd0,
        SH_FIVE = 2'd1,
        SH_TEN  = 2'd2,
        SH_END  = 2'd3
    } shape_t;

    // Letter at position k of a lower digit, with subtractive forms for 4 and 9.
    function automatic shape_t digit_shape(input logic [DIGIT_W-1:0] d,
                                           input logic [DIGIT_W-1:0] k);
        shape_t s;
        s = SH_END;
        unique case (d)
            4'd1, 4'd2, 4'd3:
            begin
                if (k < d) s = SH_ONE;
            end
            4'd4:
            begin
                if (k == 4'd0) s = SH_ONE;
                else if (k == 4'd1) s = SH_FIVE;
            end
            4'd5, 4'd6, 4'd7, 4'd8:
            begin
                if (k == 4'd0) s = SH_FIVE;
                else if (k <= d - 4'd5) s = SH_ONE;
            end
            4'd9:
            begin
                if (k == 4'd0) s = SH_ONE;
                else if (k == 4'd1) s = SH_TEN;
            end
            default:
            begin
                s = SH_END;
            end
        endcase
        return s;
    endfunction

    back_state_t         state_reg, state_next;
    digits_t             dig_reg, dig_next;
    logic [DIGIT_W-1:0]  k_reg, k_next;
    logic                ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;

    logic                out_free;
    logic [DIGIT_W-1:0]  cur_d;
    logic [CHAR_W-1:0]   l_one, l_five, l_ten;
    shape_t              shape;
    logic [CHAR_W-1:0]   sym;
    back_state_t         phase_after;

    assign out_free = !ovalid_reg || pop;

    always_comb
    begin
        cur_d       = dig_reg.on;
        l_one       = CH_I;
        l_five      = CH_V;
        l_ten       = CH_X;
        phase_after = B_NL;
        unique case (state_reg)
            B_TH:
            begin
                cur_d       = dig_reg.th;
                l_one       = CH_M;
                phase_after = B_HU;
            end
            B_HU:
            begin
                cur_d       = dig_reg.hu;
                l_one       = CH_C;
                l_five      = CH_D;
                l_ten       = CH_M;
                phase_after = B_TE;
            end
            B_TE:
            begin
                cur_d       = dig_reg.te;
                l_one       = CH_X;
                l_five      = CH_L;
                l_ten       = CH_C;
                phase_after = B_ON;
            end
            B_ON, B_IDLE, B_NL:
            begin
                cur_d       = dig_reg.on;
                phase_after = B_NL;
            end
            default:
            begin
                phase_after = B_NL;
            end
        endcase

        // Thousands are plain repeated M letters.
        if (state_reg == B_TH)
        begin
            shape = (k_reg < cur_d) ? SH_ONE : SH_END;
        end
        else
        begin
            shape = digit_shape(cur_d, k_reg);
        end

        unique case (shape)
            SH_ONE:  sym = l_one;
            SH_FIVE: sym = l_five;
            SH_TEN:  sym = l_ten;
            SH_END:  sym = l_one;
            default: sym = l_one;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        dig_next    = dig_reg;
        k_next      = k_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg && !pop;
        q_pop       = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    dig_next   = q_rdata;
                    k_next     = '0;
                    state_next = B_TH;
                end
            end
            B_TH, B_HU, B_TE, B_ON:
            begin
                if (shape == SH_END)
                begin
                    k_next     = '0;
                    state_next = phase_after;
                end
                else if (out_free)
                begin
                    char_next   = sym;
                    last_next   = 1'b0;
                    ovalid_next = 1'b1;
                    k_next      = k_reg + DIGIT_W'(1);
                end
            end
            B_NL:
            begin
                if (out_free)
                begin
                    char_next   = CH_NL;
                    last_next   = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            k_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign empty     = !ovalid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

[rtl/integer_to_roman_numeral_top.sv]
// Integer to Roman numeral converter. Each input item is one 14-bit unsigned
// value; the block returns its Roman numeral as a stream of result items, one
// ASCII character each (I V X L C D M), closed by a newline item (code 10)
// with last set. Values above 9999 are reduced modulo 10000, and a value of
// zero yields only the newline. The thousands digit becomes that many M
// letters; the lower digits use the usual subtractive forms for 4 and 9.
// Operation: the front takes an item, runs a binary to BCD conversion at one
// bit per cycle and pushes the four digits into a small queue; it accepts a
// new item only once the digits of the last one are in the queue. The back
// pops one digit set and emits one character per cycle through its output
// register while that register is free: for each item it takes the digits,
// emits each character, closes each of the four digit positions in turn and
// then emits the newline, and the character loop of the back sets the
// sustained rate for long numerals.
module integer_to_roman_numeral_top #(
    parameter int FIFO_DEPTH = i2r_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [i2r_pkg::VALUE_W-1:0] value,
    output logic                        empty,
    input  logic                        pop,
    output logic [i2r_pkg::CHAR_W-1:0]  character,
    output logic                        last
);
    import i2r_pkg::*;

    // Digit queue between the converting front and the emitting back.
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    digits_t q_wdata;
    digits_t q_rdata;

    // The front accepts an item and converts it into decimal digits.
    i2r_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .value   (value),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_wdata (q_wdata)
    );

    // The queue lets the front work on the next item while the back emits.
    i2r_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .wdata (q_wdata),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    // The back walks the digits and delivers one character item per cycle while its output register is free.
    i2r_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .character (character),
        .last      (last)
    );

    // The front never pushes into a full digit queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("digit queue pushed while full");

    // Once an item is accepted the front reports full on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("front not busy after accepting an item");

    // The last flag comes only with the newline character.
    a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (character == CH_NL))
        else $error("last flag on a character other than newline");

    // Every waiting character is a numeral letter or the newline.
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (character == CH_I || character == CH_V || character == CH_X ||
                    character == CH_L || character == CH_C || character == CH_D ||
                    character == CH_M || character == CH_NL))
        else $error("illegal character on the result port");

endmodule
